/* hdl/rmst_pkg.sv */
package rmst_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LEVELS       = IDX_W + 1;
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int TBL_DEPTH    = LEVELS * MAX_ELEMENTS;
    localparam int CFG_W        = CNT_W;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic {
        REG_ELEMENT_COUNT = 1'b0,
        REG_FIND_MAX      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [9:0]                    position;
        logic signed [VALUE_WIDTH-1:0] element_value;
        logic [9:0]                    range_left;
        logic [9:0]                    range_right;
    } in_word_t;

    typedef struct packed {
        logic [9:0]                    best_index;
        logic signed [VALUE_WIDTH-1:0] best_value;
        logic                          table_ready;
    } out_word_t;

    typedef struct packed {
        op_t                           op;
        logic [IDX_W-1:0]              pos;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]              col_a;
        logic [IDX_W-1:0]              col_b;
        logic [LVL_W-1:0]              lvl;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             find_max;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B0,
        ST_B_IDX,
        ST_B_VAL,
        ST_B_CMP,
        ST_Q_IDX,
        ST_Q_VAL,
        ST_Q_CMP
    } state_t;

    function automatic logic [CNT_W-1:0] live_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (cnt == '0) begin
            n = CNT_W'(1);
        end else if (cnt > CNT_W'(MAX_ELEMENTS)) begin
            n = CNT_W'(MAX_ELEMENTS);
        end
        return n;
    endfunction

    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/rmst_ram.sv */
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

/* hdl/rmst_front.sv */
module rmst_front import rmst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_word,
    input  cfg_t       cfg,
    output logic       q_valid,
    output cmd_t       q_cmd,
    input  logic       q_pop
);

    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] nm1, lo, hi;
    logic [CNT_W-1:0] len;
    logic [LVL_W-1:0] lvl;
    logic [CNT_W-1:0] start_b;
    cmd_t             cmd;
    logic             keep;
    logic             push;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    // classify: order and clamp the bounds, pick the level
    always_comb begin
        n   = live_count(cfg.count);
        nm1 = IDX_W'(n - CNT_W'(1));
        if (s_word.range_left > s_word.range_right) begin
            lo = s_word.range_right;
            hi = s_word.range_left;
        end else begin
            lo = s_word.range_left;
            hi = s_word.range_right;
        end
        if (hi > nm1) begin
            hi = nm1;
        end
        if (lo > nm1) begin
            lo = nm1;
        end
        len     = {1'b0, hi} - {1'b0, lo} + CNT_W'(1);
        lvl     = floor_log2(len);
        start_b = {1'b0, hi} + CNT_W'(1) - (CNT_W'(1) << lvl);

        cmd       = '0;
        cmd.pos   = s_word.position;
        cmd.value = s_word.element_value;
        cmd.col_a = lo;
        cmd.col_b = IDX_W'(start_b);
        cmd.lvl   = lvl;
        keep      = 1'b1;
        unique case (s_word.opcode)
            OP_LOAD:  cmd.op = OP_LOAD;
            OP_BUILD: cmd.op = OP_BUILD;
            OP_QUERY: cmd.op = OP_QUERY;
            default:  keep   = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

/* hdl/rmst_back.sv */
module rmst_back import rmst_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    input  cfg_t      cfg,
    input  logic      cfg_wr,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int TBL_AW = $clog2(TBL_DEPTH);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [LVL_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic      built_reg, built_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] nm1;
    logic [LVL_W-1:0] lvl_top;
    logic [CNT_W-1:0] nxt_sum;
    logic [IDX_W-1:0] nxt;
    logic             out_free;
    logic             b_wins;
    logic [IDX_W-1:0] win_idx;
    logic signed [VALUE_WIDTH-1:0] win_val;

    logic                   tbl_we, tbl_re;
    logic [TBL_AW-1:0]      tbl_waddr, tbl_raddr0, tbl_raddr1;
    logic [IDX_W-1:0]       tbl_wdata, tbl_rdata0, tbl_rdata1;
    logic                   val_we, val_re;
    logic [IDX_W-1:0]       val_waddr, val_raddr0, val_raddr1;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata0, val_rdata1;

    rmst_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_tbl (
        .aclk   (aclk),
        .we     (tbl_we),
        .waddr  (tbl_waddr),
        .wdata  (tbl_wdata),
        .re     (tbl_re),
        .raddr0 (tbl_raddr0),
        .raddr1 (tbl_raddr1),
        .rdata0 (tbl_rdata0),
        .rdata1 (tbl_rdata1)
    );

    rmst_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_val (
        .aclk   (aclk),
        .we     (val_we),
        .waddr  (val_waddr),
        .wdata  (val_wdata),
        .re     (val_re),
        .raddr0 (val_raddr0),
        .raddr1 (val_raddr1),
        .rdata0 (val_rdata0),
        .rdata1 (val_rdata1)
    );

    always_comb begin
        n        = live_count(cfg.count);
        nm1      = IDX_W'(n - CNT_W'(1));
        lvl_top  = floor_log2(n);
        nxt_sum  = {1'b0, j_reg} + (CNT_W'(1) << (k_reg - LVL_W'(1)));
        nxt      = (nxt_sum > {1'b0, nm1}) ? nm1 : IDX_W'(nxt_sum);
        out_free = !out_valid_reg || m_ready;
        b_wins   = cfg.find_max ? ($signed(val_rdata1) > $signed(val_rdata0))
                                : ($signed(val_rdata1) < $signed(val_rdata0));
        win_idx  = b_wins ? b_reg : a_reg;
        win_val  = b_wins ? $signed(val_rdata1) : $signed(val_rdata0);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        OP_BUILD: state_next = ST_B0;
                        OP_QUERY: state_next = ST_Q_IDX;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B0: begin
                if (j_reg == nm1) begin
                    state_next = (lvl_top == '0) ? ST_IDLE : ST_B_IDX;
                end
            end
            ST_B_IDX: state_next = ST_B_VAL;
            ST_B_VAL: state_next = ST_B_CMP;
            ST_B_CMP: begin
                if (j_reg == nm1 && k_reg == lvl_top) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_B_IDX;
                end
            end
            ST_Q_IDX: state_next = ST_Q_VAL;
            ST_Q_VAL: state_next = ST_Q_CMP;
            ST_Q_CMP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop          = 1'b0;
        cmd_next       = cmd_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        built_next     = built_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_word_next  = out_word_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = {k_reg, j_reg};
        tbl_wdata      = j_reg;
        tbl_re         = 1'b0;
        tbl_raddr0     = {k_reg - LVL_W'(1), j_reg};
        tbl_raddr1     = {k_reg - LVL_W'(1), nxt};
        val_we         = 1'b0;
        val_waddr      = q_cmd.pos;
        val_wdata      = q_cmd.value;
        val_re         = 1'b0;
        val_raddr0     = tbl_rdata0;
        val_raddr1     = tbl_rdata1;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    j_next   = '0;
                    if (q_cmd.op == OP_LOAD) begin
                        val_we     = 1'b1;
                        built_next = 1'b0;
                    end
                end
            end
            ST_B0: begin
                tbl_we    = 1'b1;
                tbl_waddr = {LVL_W'(0), j_reg};
                j_next    = j_reg + IDX_W'(1);
                if (j_reg == nm1) begin
                    j_next = '0;
                    k_next = LVL_W'(1);
                    if (lvl_top == '0) begin
                        built_next = 1'b1;
                    end
                end
            end
            ST_B_IDX: begin
                tbl_re = 1'b1;
            end
            ST_B_VAL, ST_Q_VAL: begin
                val_re = 1'b1;
                a_next = tbl_rdata0;
                b_next = tbl_rdata1;
            end
            ST_B_CMP: begin
                tbl_we    = 1'b1;
                tbl_wdata = win_idx;
                j_next    = j_reg + IDX_W'(1);
                if (j_reg == nm1) begin
                    j_next = '0;
                    k_next = k_reg + LVL_W'(1);
                    if (k_reg == lvl_top) begin
                        built_next = 1'b1;
                    end
                end
            end
            ST_Q_IDX: begin
                tbl_re     = 1'b1;
                tbl_raddr0 = {cmd_reg.lvl, cmd_reg.col_a};
                tbl_raddr1 = {cmd_reg.lvl, cmd_reg.col_b};
            end
            ST_Q_CMP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    if (built_reg) begin
                        out_word_next.best_index  = win_idx;
                        out_word_next.best_value  = win_val;
                        out_word_next.table_ready = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // a register write invalidates the table
        if (cfg_wr) begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

/* hdl/range_min_sparse_table_top.sv */
// Load: queued, then written to the store when the sequencer pops it. Build: level 0, then
// a table read, value read and compare-write per entry of each level. Query: queue, table read, value read, compare.
// The back-end sequencer takes one load every cycle while idle; a build or query holds it.
// Reset (aresetn low, synchronous) clears the queue, sequencer, output valid flag and
// built flag; registers return to count 1 and minimum mode. Memories are not cleared.
module range_min_sparse_table_top import rmst_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_word,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t cfg_reg;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    // Register file: hold count and compare mode between writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count    <= CNT_W'(1);
            cfg_reg.find_max <= 1'b0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ELEMENT_COUNT: cfg_reg.count    <= cfg_wdata[CNT_W-1:0];
                REG_FIND_MAX:      cfg_reg.find_max <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Front: classify each word, drop unused opcodes, queue commands.
    rmst_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // Back: advance loads, table builds and queries; any register write drops the table.
    rmst_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .cfg_wr  (cfg_we),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

/* hdl/rmst_checker.sv */
module rmst_checker import rmst_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input in_word_t         s_word,
    input logic             m_valid,
    input logic             m_ready,
    input out_word_t        m_word,
    input logic             cfg_we,
    input logic             cfg_index,
    input logic [CFG_W-1:0] cfg_wdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.table_ready |-> m_word.best_index == '0 && m_word.best_value == '0)
        else $error("invalid result carries nonzero payload");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind range_min_sparse_table_top rmst_checker u_rmst_checker (.*);

/* tb/tb_range_min_sparse_table_top.sv */
module tb_range_min_sparse_table_top;
    import rmst_pkg::*;

    // Expected query answers, oldest first, and the predictor's own copy of the block state.
    class query_scoreboard;
        out_word_t  pending[$];
        logic signed [31:0] vals[1024];
        logic [9:0] lvl_tab[11][1024];
        bit         built;
        int         count;
        bit         want_max;
        int         errors;

        function new();
            built = 0;
            count = 1;
            want_max = 0;
            errors = 0;
        endfunction

        function int live_n();
            if (count == 0) return 1;
            if (count > 1024) return 1024;
            return count;
        endfunction

        function int log2_floor(int v);
            int r;
            r = 0;
            while (v > 1) begin
                v = v >> 1;
                r++;
            end
            return r;
        endfunction

        // True when the element at idx_b strictly beats the one at idx_a.
        function bit wins(int idx_b, int idx_a);
            if (want_max) return vals[idx_b] > vals[idx_a];
            return vals[idx_b] < vals[idx_a];
        endfunction

        function void set_reg(reg_idx_t idx, int data);
            if (idx == REG_ELEMENT_COUNT) count = data & 11'h7ff;
            else want_max = data & 1;
            built = 0;
        endfunction

        function void note_input(in_word_t w);
            int n, lo, hi, lv, a, b, t, nxt, k, j;
            out_word_t r;
            n = live_n();
            case (w.opcode)
                OP_LOAD: begin
                    vals[w.position] = w.element_value;
                    built = 0;
                end
                OP_BUILD: begin
                    for (j = 0; j < n; j++) lvl_tab[0][j] = 10'(j);
                    for (k = 1; k <= log2_floor(n); k++) begin
                        for (j = 0; j < n; j++) begin
                            nxt = j + (1 << (k - 1));
                            if (nxt > n - 1) nxt = n - 1;
                            a = lvl_tab[k-1][j];
                            b = lvl_tab[k-1][nxt];
                            lvl_tab[k][j] = 10'(wins(b, a) ? b : a);
                        end
                    end
                    built = 1;
                end
                OP_QUERY: begin
                    r = '0;
                    if (built) begin
                        lo = w.range_left;
                        hi = w.range_right;
                        if (lo > hi) begin
                            t = lo; lo = hi; hi = t;
                        end
                        if (hi > n - 1) hi = n - 1;
                        if (lo > n - 1) lo = n - 1;
                        lv = log2_floor(hi - lo + 1);
                        a = lvl_tab[lv][lo];
                        b = lvl_tab[lv][hi + 1 - (1 << lv)];
                        t = wins(b, a) ? b : a;
                        r.best_index = 10'(t);
                        r.best_value = vals[t];
                        r.table_ready = 1;
                    end
                    pending.insert(pending.size(), r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.best_index !== want.best_index) begin
                $display("%0t: best_index expected %0d actual %0d", $time,
                         want.best_index, got.best_index);
                errors++;
            end
            if (got.best_value !== want.best_value) begin
                $display("%0t: best_value expected %0d actual %0d", $time,
                         want.best_value, got.best_value);
                errors++;
            end
            if (got.table_ready !== want.table_ready) begin
                $display("%0t: table_ready expected %0d actual %0d", $time,
                         want.table_ready, got.table_ready);
                errors++;
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    in_word_t        s_word;
    logic            m_valid;
    logic            m_ready;
    out_word_t       m_word;
    logic            cfg_we;
    logic            cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    query_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  cycle_cnt;
    // Track which store entries have been written so builds never read junk.
    bit  loaded[1024];

    localparam int CYCLE_LIMIT = 10000000;

    range_min_sparse_table_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Bound the run; a hang anywhere ends here.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("** range_min_sparse_table_top: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: sample at the rising edge, change ready at the falling edge.
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_word);
            @(negedge aclk);
            m_ready = !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one word; hold valid and payload until the block takes it.
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1;
        s_word  = w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        @(negedge aclk);
        s_valid = 0;
    endtask

    // Wait out every pending answer plus the longest build.
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40000) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int data);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_wdata = CFG_W'(data);
        @(negedge aclk);
        cfg_we = 0;
        sb.set_reg(idx, data);
    endtask

    task automatic load(int pos, logic signed [31:0] v);
        in_word_t w;
        w = '0;
        w.opcode = OP_LOAD;
        w.position = 10'(pos);
        w.element_value = v;
        w.range_left = 10'($urandom);
        w.range_right = 10'($urandom);
        loaded[pos] = 1;
        send_word(w);
    endtask

    task automatic build();
        in_word_t w;
        w = {$urandom, $urandom};
        w.opcode = OP_BUILD;
        send_word(w);
    endtask

    task automatic query(int lft, int rgt);
        in_word_t w;
        w = {$urandom, $urandom};
        w.opcode = OP_QUERY;
        w.range_left = 10'(lft);
        w.range_right = 10'(rgt);
        send_word(w);
    endtask

    task automatic junk();
        in_word_t w;
        w = {$urandom, $urandom};
        w.opcode = 2'd3;
        send_word(w);
    endtask

    // Load any never-written element below n, then build.
    task automatic fill_and_build(int n);
        for (int i = 0; i < n && i < 1024; i++)
            if (!loaded[i]) load(i, $urandom);
        build();
    endtask

    // Draw a value with many ties so the leftmost rule is exercised.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return 32'sh8000_0000 + $urandom_range(1);
            2: return 32'sh7fff_ffff - $urandom_range(1);
            default: return $urandom;
        endcase
    endfunction

    // One random phase: reloads, rebuilds and queries on a chosen count.
    task automatic random_phase(int items, int n, bit mx);
        int k;
        drain();
        write_reg(REG_ELEMENT_COUNT, n);
        write_reg(REG_FIND_MAX, mx);
        fill_and_build(sb.live_n());
        for (k = 0; k < items; k++) begin
            case ($urandom_range(19))
                0, 1: load($urandom_range(sb.live_n() - 1), pick_value());
                2:    build();
                3:    junk();
                4:    load($urandom_range(1023), pick_value());
                default: query($urandom_range(1023), $urandom_range(1023));
            endcase
        end
    endtask

    initial begin
        sb = new();
        s_valid = 0;
        s_word = '0;
        cfg_we = 0;
        cfg_index = REG_ELEMENT_COUNT;
        cfg_wdata = '0;
        hold_recv = 0;
        send_idle_pct = 18;
        recv_idle_pct = 81;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: query before any build, count 1, extremes, swaps, clamps, ties.
        load(0, 32'sh7fff_ffff);
        query(0, 0);
        build();
        query(1023, 0);
        junk();
        drain();
        write_reg(REG_ELEMENT_COUNT, 9);
        for (int i = 0; i < 9; i++) load(i, (i == 2 || i == 6) ? 32'sh8000_0000 : i);
        query(0, 8);
        build();
        query(8, 0);
        query(3, 1023);
        query(5, 5);
        query(7, 8);
        load(1023, 32'sh1234_5678);
        query(0, 8);
        build();
        drain();
        write_reg(REG_FIND_MAX, 1);
        query(0, 8);
        build();
        query(0, 1023);
        query(1023, 1023);
        drain();
        write_reg(REG_ELEMENT_COUNT, 0);
        build();
        query(1023, 512);
        drain();
        write_reg(REG_ELEMENT_COUNT, 2047);
        write_reg(REG_FIND_MAX, 0);
        fill_and_build(1024);
        query(0, 1023);
        query(1023, 512);

        // Random phases across the idling patterns and a range of counts.
        random_phase(120, $urandom_range(2, 40), 0);
        random_phase(120, $urandom_range(40, 200), 1);
        send_idle_pct = 81;
        recv_idle_pct = 18;
        random_phase(120, $urandom_range(1, 64), 1);
        random_phase(120, 1024, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120, $urandom_range(2, 300), 0);

        // Stall the receiver for a long stretch while queries keep coming.
        fork
            begin
                hold_recv = 1;
                repeat (400) @(negedge aclk);
                hold_recv = 0;
            end
            for (int i = 0; i < 60; i++) query($urandom_range(1023), $urandom_range(1023));
        join

        // Pause the sender until the queue of answers empties, then run one more random phase.
        while (sb.pending.size() != 0) @(negedge aclk);
        random_phase(120, $urandom_range(2, 1024), 1);

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** range_min_sparse_table_top: PASSED **");
        end else begin
            $display("** range_min_sparse_table_top: FAILED **");
        end
        $finish;
    end

endmodule
